// ----- rtl/core/gda_pkg.sv -----
// Shared types and constants of the Gregorian date unit.
`timescale 1ns / 1ps
package gda_pkg;

    localparam int YEAR_MAX = 9999;
    localparam int YEAR_W   = 14;
    localparam int SER_W    = 23;
    localparam int YEAR_LO  = 1900;
    localparam int YEAR_HI  = 2100;

    // Zero-based day count of YEAR_MAX-12-31
    localparam logic [SER_W-1:0] DATE_TOP = SER_W'(365 * (YEAR_MAX + 1) + (YEAR_MAX + 4) / 4
        - (YEAR_MAX + 100) / 100 + (YEAR_MAX + 400) / 400 - 1);

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_ADD  = 2'd1,
        OP_DIFF = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        logic cap_in;
        logic arg_cur;
        logic set_cur;
        logic save_given;
        logic calc_diff;
        logic calc_t;
        logic srch_init;
        logic srch_step;
        logic arg_cand;
        logic arg_year;
        logic rem_init;
        logic mon_step;
        logic commit_add;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic srch_last;
        logic mon_done;
    } t_sts;

endpackage

// ----- rtl/core/gda_dby.sv -----
// Two-stage unit: days before a year and the leap flag of that year.
`timescale 1ns / 1ps
module gda_dby (
    input  logic                      i_clk,
    input  logic [gda_pkg::YEAR_W-1:0] i_arg,
    output logic [gda_pkg::SER_W-1:0]  o_dby,
    output logic                      o_leap
);
    import gda_pkg::*;

    // floor(x/100) = (x * 5243) >> 19 for x below 43699
    localparam logic [12:0] RECIP100 = 13'd5243;
    localparam int          RSH      = 19;

    logic [14:0]       a100;
    logic [14:0]       a400;
    logic [14:0]       a4;
    logic [27:0]       prod100;
    logic [25:0]       prod400;
    logic [SER_W-1:0]  r_p365;
    logic [12:0]       r_c4;
    logic [8:0]        r_c100;
    logic [6:0]        r_c400;
    logic [YEAR_W-1:0] r_a1;
    logic              n_leap;

    always_comb begin
        a100    = 15'(i_arg) + 15'd99;
        a400    = 15'(i_arg) + 15'd399;
        a4      = 15'(i_arg) + 15'd3;
        prod100 = 28'(a100) * 28'(RECIP100);
        prod400 = 26'(a400[14:2]) * 26'(RECIP100);
    end

    always_ff @(posedge i_clk) begin
        r_p365 <= SER_W'(i_arg) * SER_W'(365);
        r_c4   <= a4[14:2];
        r_c100 <= prod100[RSH+8:RSH];
        r_c400 <= prod400[RSH+6:RSH];
        r_a1   <= i_arg;
    end

    // ceil(y/100)*100 == y marks a century year
    always_comb begin
        n_leap = (r_a1[1:0] == 2'b00)
            && !((16'(r_c100) * 16'd100 == 16'(r_a1))
                 && (16'(r_c400) * 16'd400 != 16'(r_a1)));
    end

    always_ff @(posedge i_clk) begin
        o_dby  <= r_p365 + SER_W'(r_c4) - SER_W'(r_c100) + SER_W'(r_c400);
        o_leap <= n_leap;
    end

endmodule

// ----- rtl/core/gda_dp.sv -----
// Datapath: stored date, clamping, serial arithmetic, year search and month walk.
`timescale 1ns / 1ps
module gda_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gda_pkg::t_cmd       i_cmd,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_day_in,
    input  logic [7:0]          i_month_in,
    input  logic [15:0]         i_year_in,
    input  logic signed [21:0]  i_day_delta,
    output gda_pkg::t_sts       o_sts,
    output logic [4:0]          o_day_out,
    output logic [3:0]          o_month_out,
    output logic [13:0]         o_year_out,
    output logic [8:0]          o_day_of_year,
    output logic signed [22:0]  o_days_diff,
    output logic                o_range_flag
);
    import gda_pkg::*;

    function automatic logic [4:0] f_mdays(input logic [3:0] m, input logic lp);
        logic [4:0] n;
        unique case (m)
            4'd2:                      n = lp ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] f_mstart(input logic [3:0] m);
        logic [8:0] s;
        unique case (m)
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [8:0] f_ord(input logic [4:0] d, input logic [3:0] m,
                                         input logic lp);
        return f_mstart(m) + 9'(d) + ((m > 4'd2 && lp) ? 9'd1 : 9'd0);
    endfunction

    function automatic logic [4:0] f_clamp_day(input logic [7:0] d, input logic [4:0] lim);
        logic [4:0] r;
        if (d == 8'd0)          r = 5'd1;
        else if (d > 8'(lim))   r = lim;
        else                    r = d[4:0];
        return r;
    endfunction

    logic [YEAR_W-1:0]       r_arg;
    logic [YEAR_W-1:0]       n_arg;
    logic [SER_W-1:0]        dby;
    logic                    leap;
    logic [7:0]              r_gd;
    logic [3:0]              r_gm;
    logic [YEAR_W-1:0]       in_yy;
    logic [3:0]              in_mm;
    logic signed [21:0]      r_delta;
    logic [4:0]              r_cur_day;
    logic [3:0]              r_cur_month;
    logic [YEAR_W-1:0]       r_cur_year;
    logic                    r_cur_leap;
    logic [SER_W-1:0]        r_sg;
    logic signed [22:0]      r_diff;
    logic                    r_flag;
    logic [SER_W-1:0]        r_t;
    logic [YEAR_W-1:0]       r_y;
    logic [YEAR_W-1:0]       n_y;
    logic [3:0]              r_k;
    logic [3:0]              n_k;
    logic [YEAR_W-1:0]       cand;
    logic                    keep;
    logic [8:0]              r_rem;
    logic [3:0]              r_mon;
    logic                    r_yleap;
    logic [4:0]              g_day;
    logic [4:0]              rem_md;
    logic [SER_W-1:0]        ser_cur;
    logic signed [SER_W+1:0] t_raw;
    logic signed [SER_W:0]   d_raw;

    gda_dby u_dby (
        .i_clk  (i_clk),
        .i_arg  (r_arg),
        .o_dby  (dby),
        .o_leap (leap)
    );

    always_comb begin
        if (i_year_in < 16'(YEAR_LO))      in_yy = YEAR_W'(YEAR_LO);
        else if (i_year_in > 16'(YEAR_HI)) in_yy = YEAR_W'(YEAR_HI);
        else                               in_yy = i_year_in[YEAR_W-1:0];
        if (i_month_in == 8'd0)            in_mm = 4'd1;
        else if (i_month_in > 8'd12)       in_mm = 4'd12;
        else                               in_mm = i_month_in[3:0];
    end

    // Year search: one bit per pass, keep it while the count still fits
    always_comb begin
        cand = r_y | (YEAR_W'(1) << r_k);
        keep = (cand <= YEAR_W'(YEAR_MAX)) && (dby <= r_t);
        n_y  = r_y;
        n_k  = r_k;
        if (i_cmd.srch_init) begin
            n_y = '0;
            n_k = 4'(YEAR_W - 1);
        end else if (i_cmd.srch_step) begin
            n_y = keep ? cand : r_y;
            n_k = r_k - 4'd1;
        end
    end

    always_comb begin
        n_arg = r_arg;
        if (i_cmd.cap_in)
            n_arg = (t_op'(i_op) == OP_ADD) ? r_cur_year : in_yy;
        else if (i_cmd.arg_cur)
            n_arg = r_cur_year;
        else if (i_cmd.arg_cand)
            n_arg = n_y | (YEAR_W'(1) << n_k);
        else if (i_cmd.arg_year)
            n_arg = n_y;
    end

    always_comb begin
        g_day   = f_clamp_day(r_gd, f_mdays(r_gm, leap));
        ser_cur = dby + SER_W'(f_ord(r_cur_day, r_cur_month, r_cur_leap));
        t_raw   = $signed({2'b00, ser_cur}) - 25'sd1 + 25'(r_delta);
        d_raw   = $signed({1'b0, ser_cur}) - $signed({1'b0, r_sg});
        rem_md  = f_mdays(r_mon, r_yleap);
    end

    assign o_sts.srch_last = (r_k == 4'd0);
    assign o_sts.mon_done  = (r_mon == 4'd12) || (r_rem < 9'(rem_md));

    always_ff @(posedge i_clk) begin
        r_arg <= n_arg;
        r_y   <= n_y;
        r_k   <= n_k;
        if (i_cmd.cap_in) begin
            r_gd    <= i_day_in;
            r_gm    <= in_mm;
            r_delta <= i_day_delta;
            r_diff  <= '0;
            r_flag  <= 1'b0;
        end
        if (i_cmd.save_given)
            r_sg <= dby + SER_W'(f_ord(g_day, r_gm, leap));
        if (i_cmd.calc_diff) begin
            if (d_raw > 24'sd4194303)       r_diff <= 23'sh3FFFFF;
            else if (d_raw < -24'sd4194304) r_diff <= 23'sh400000;
            else                            r_diff <= d_raw[22:0];
        end
        // Saturate the new day count at both ends of the range
        if (i_cmd.calc_t) begin
            if (t_raw < 0) begin
                r_t    <= '0;
                r_flag <= 1'b1;
            end else if (t_raw > $signed({2'b00, DATE_TOP})) begin
                r_t    <= DATE_TOP;
                r_flag <= 1'b1;
            end else begin
                r_t <= t_raw[SER_W-1:0];
            end
        end
        if (i_cmd.rem_init) begin
            r_rem   <= 9'(r_t - dby);
            r_mon   <= 4'd1;
            r_yleap <= leap;
        end else if (i_cmd.mon_step) begin
            r_rem <= r_rem - 9'(rem_md);
            r_mon <= r_mon + 4'd1;
        end
        if (i_cmd.out_load) begin
            o_day_out     <= r_cur_day;
            o_month_out   <= r_cur_month;
            o_year_out    <= r_cur_year;
            o_day_of_year <= f_ord(r_cur_day, r_cur_month, r_cur_leap);
            o_days_diff   <= r_diff;
            o_range_flag  <= r_flag;
        end
    end

    // Clamped year of a set stays in the unit argument until the unit answers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_day   <= 5'd1;
            r_cur_month <= 4'd1;
            r_cur_year  <= YEAR_W'(2000);
            r_cur_leap  <= 1'b1;
        end else if (i_cmd.set_cur) begin
            r_cur_day   <= g_day;
            r_cur_month <= r_gm;
            r_cur_year  <= r_arg;
            r_cur_leap  <= leap;
        end else if (i_cmd.commit_add) begin
            r_cur_day   <= 5'(r_rem + 9'd1);
            r_cur_month <= r_mon;
            r_cur_year  <= r_y;
            r_cur_leap  <= r_yleap;
        end
    end

endmodule

// ----- rtl/core/gda_ctrl.sv -----
// Controller: sequences the datapath through each date operation.
`timescale 1ns / 1ps
module gda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gda_pkg::t_cmd o_cmd,
    input  gda_pkg::t_sts i_sts
);
    import gda_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_W1, S_W2, S_SET, S_DGIV, S_DCUR, S_ACUR, S_SRCH, S_YEAR, S_MON, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_W1;
                    unique case (t_op'(i_op))
                        OP_SET:  n_ret = S_SET;
                        OP_ADD:  n_ret = S_ACUR;
                        OP_DIFF: n_ret = S_DGIV;
                        OP_NONE: n_state = S_DONE;
                    endcase
                end
            end
            S_W1: n_state = S_W2;
            S_W2: n_state = r_ret;
            S_SET: begin
                o_cmd.set_cur = 1'b1;
                n_state       = S_DONE;
            end
            S_DGIV: begin
                o_cmd.save_given = 1'b1;
                o_cmd.arg_cur    = 1'b1;
                n_ret            = S_DCUR;
                n_state          = S_W1;
            end
            S_DCUR: begin
                o_cmd.calc_diff = 1'b1;
                n_state         = S_DONE;
            end
            S_ACUR: begin
                o_cmd.calc_t    = 1'b1;
                o_cmd.srch_init = 1'b1;
                o_cmd.arg_cand  = 1'b1;
                n_ret           = S_SRCH;
                n_state         = S_W1;
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                n_state         = S_W1;
                if (i_sts.srch_last) begin
                    o_cmd.arg_year = 1'b1;
                    n_ret          = S_YEAR;
                end else begin
                    o_cmd.arg_cand = 1'b1;
                end
            end
            S_YEAR: begin
                o_cmd.rem_init = 1'b1;
                n_state        = S_MON;
            end
            S_MON: begin
                if (i_sts.mon_done) begin
                    o_cmd.commit_add = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.mon_step = 1'b1;
                end
            end
            S_DONE: begin
                // hold the word until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (o_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

endmodule

// ----- rtl/core/gregorian_date_arithmetic.sv -----
// Top level of the Gregorian date unit: stream ports, controller and datapath.
//
//  channel | direction | tdata (low bit up)                           | tuser
//  s_axis  | in        | day_in 8, month_in 8, year_in 16, day_delta 22 | op 2
//  m_axis  | out       | day_out 5, month_out 4, year_out 14,           | range_flag 1
//          |           | day_of_year 9, days_diff 23                    |
//
// One word at a time. Set and diff take short paths to a result, add the longest:
// the year of the new day count is found bit by bit, 14 passes through the
// day-count unit, then a walk over the months of that year.
// The next word is taken as soon as the result sits in the output register.
// Synchronous reset loads 2000-01-01; a stalled output holds its word.
`timescale 1ns / 1ps
module gregorian_date_arithmetic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // day_in, month_in, year_in, day_delta
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // day_out, month_out, year_out, day_of_year, days_diff
    output logic        m_axis_tuser    // range_flag
);
    import gda_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic [4:0]         day_out;
    logic [3:0]         month_out;
    logic [13:0]        year_out;
    logic [8:0]         day_of_year;
    logic signed [22:0] days_diff;

    gda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gda_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (s_axis_tuser),
        .i_day_in      (s_axis_tdata[7:0]),
        .i_month_in    (s_axis_tdata[15:8]),
        .i_year_in     (s_axis_tdata[31:16]),
        .i_day_delta   ($signed(s_axis_tdata[53:32])),
        .o_sts         (sts),
        .o_day_out     (day_out),
        .o_month_out   (month_out),
        .o_year_out    (year_out),
        .o_day_of_year (day_of_year),
        .o_days_diff   (days_diff),
        .o_range_flag  (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, days_diff, day_of_year, year_out, month_out, day_out};

endmodule

// ----- rtl/core/gda_chk.sv -----
// Port checker of the Gregorian date unit and its bind.
`timescale 1ns / 1ps
module gda_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while a word is in work");

    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[8:5] != 4'd0 && m_axis_tdata[8:5] <= 4'd12
            && m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[31:23] != 9'd0)
        else $error("output date out of range");

    a_flag_no_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[54:32] == 23'd0)
        else $error("range flag with nonzero difference");

endmodule

bind gregorian_date_arithmetic gda_chk u_gda_chk (.*);

// ----- sim/gda_checker.sv -----
// Checker of the Gregorian date unit: predicts each result word and compares it.
`timescale 1ns / 1ps
module gda_checker
    import gda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [55:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [55:0] i_out_data,
    input  logic        i_out_user,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [22:0] diff;
        logic [8:0]  doy;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date_word;

    typedef struct {
        t_date_word w;
        logic       flag;
    } t_date_result;

    t_date_result date_results_q[$];
    longint cal_day, cal_month, cal_year;

    function automatic bit is_leap(longint y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic longint days_to_year(longint y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic longint month_length(longint m, longint y);
        longint lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && is_leap(y)) return 29;
        return lens[m - 1];
    endfunction

    function automatic longint day_in_year(longint d, longint m, longint y);
        longint starts[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        longint n;
        n = starts[m - 1] + d;
        if (m > 2 && is_leap(y)) n++;
        return n;
    endfunction

    function automatic longint day_serial(longint d, longint m, longint y);
        return days_to_year(y) + day_in_year(d, m, y);
    endfunction

    task automatic clamp(input longint d, m, y, output longint od, om, oy);
        longint lim;
        oy = y < YEAR_LO ? YEAR_LO : y > YEAR_HI ? YEAR_HI : y;
        om = m < 1 ? 1 : m > 12 ? 12 : m;
        lim = month_length(om, oy);
        od = d < 1 ? 1 : d > lim ? lim : d;
    endtask

    task automatic predict_date(input logic [55:0] data, input t_op op);
        longint d, m, y, gd, gm, gy, t, top, yy, mm, diff;
        t_date_result r;
        d = longint'(data[7:0]); m = longint'(data[15:8]); y = longint'(data[31:16]);
        diff = 0;
        r.flag = 1'b0;
        case (op)
            OP_SET: clamp(d, m, y, cal_day, cal_month, cal_year);
            OP_ADD: begin
                top = days_to_year(YEAR_MAX + 1) - 1;
                t = day_serial(cal_day, cal_month, cal_year) - 1
                    + longint'($signed(data[53:32]));
                if (t < 0) begin
                    t = 0; r.flag = 1'b1;
                end else if (t > top) begin
                    t = top; r.flag = 1'b1;
                end
                yy = (t * 400) / 146097;
                if (yy > YEAR_MAX) yy = YEAR_MAX;
                while (yy > 0 && days_to_year(yy) > t) yy--;
                while (yy < YEAR_MAX && days_to_year(yy + 1) <= t) yy++;
                t -= days_to_year(yy);
                mm = 1;
                while (mm < 12 && t >= month_length(mm, yy)) begin
                    t -= month_length(mm, yy);
                    mm++;
                end
                cal_year = yy; cal_month = mm; cal_day = t + 1;
            end
            OP_DIFF: begin
                clamp(d, m, y, gd, gm, gy);
                diff = day_serial(cal_day, cal_month, cal_year) - day_serial(gd, gm, gy);
                if (diff > 4194303) diff = 4194303;
                if (diff < -4194304) diff = -4194304;
            end
            default: ;
        endcase
        r.w.day   = cal_day[4:0];
        r.w.month = cal_month[3:0];
        r.w.year  = cal_year[13:0];
        r.w.doy   = 9'(day_in_year(cal_day, cal_month, cal_year));
        r.w.diff  = diff[22:0];
        date_results_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_date_result r;
        t_date_word got;
        if (!i_rst_n) begin
            cal_day = 1; cal_month = 1; cal_year = 2000;
            date_results_q.delete();
            o_fail_count <= 0;
        end else begin
            // Compare before predicting: the block cannot answer a word in its own cycle
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[54:0];
                if (date_results_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10) $display("unexpected word %h", i_out_data);
                end else begin
                    r = date_results_q.pop_front();
                    if (got !== r.w || i_out_user !== r.flag) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: exp %h/%b got %h/%b", r.w, r.flag,
                                     i_out_data, i_out_user);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_date(i_in_data, t_op'(i_in_user));
        end
        o_pending <= date_results_q.size();
    end

endmodule

// ----- sim/gregorian_date_arithmetic_tb.sv -----
// Testbench top of the Gregorian date unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module gregorian_date_arithmetic_tb;
    import gda_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [55:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [55:0] m_data;
    logic        m_user;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;

    initial forever #2 i_clk = ~i_clk;

    gregorian_date_arithmetic DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user)
    );

    gda_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data), .i_in_user(s_user),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_out_user(m_user), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: own stall pattern, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drive one word and hold it until it is taken; valid stays up for the next word
    task automatic send_word(input t_op op, input logic [7:0] d, m, input logic [15:0] y,
                             input logic [21:0] delta);
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {2'b00, delta, y, m, d};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic send_random(input int n);
        t_op op;
        logic [15:0] y;
        logic [21:0] delta;
        int burst;
        int gap;
        burst = 0;
        repeat (n) begin
            if (burst == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 20);
            end
            burst--;
            op = t_op'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
            y = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1890, 2110));
            case ($urandom_range(0, 3))
                0: delta = 22'($urandom);
                1: delta = 22'($signed($urandom_range(0, 2000)) - 1000);
                default: delta = 22'($signed($urandom_range(0, 200000)) - 100000);
            endcase
            send_word(op, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 32)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 13)),
                      y, delta);
        end
    endtask

    // Drop valid, let the count of open words settle, then wait for it to empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: extremes, leap rules, saturation both ways, unused op
        send_word(OP_NONE, 8'd0, 8'd0, 16'd0, 22'd0);
        send_word(OP_SET, 8'd0, 8'd0, 16'd0, 22'd0);
        send_word(OP_SET, 8'hFF, 8'hFF, 16'hFFFF, 22'd0);
        send_word(OP_SET, 8'd31, 8'd2, 16'd2000, 22'd0);
        send_word(OP_SET, 8'd29, 8'd2, 16'd1900, 22'd0);
        send_word(OP_SET, 8'd29, 8'd2, 16'd2024, 22'd0);
        send_word(OP_ADD, 8'hFF, 8'hFF, 16'hFFFF, 22'd1);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'd365);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'h200000);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'h1FFFFF);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'h1FFFFF);
        send_word(OP_DIFF, 8'd1, 8'd1, 16'd1900, 22'd0);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'h3FFFFF);
        send_word(OP_DIFF, 8'hFF, 8'hFF, 16'hFFFF, 22'h3FFFFF);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'h200000);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'h200000);
        send_word(OP_DIFF, 8'd31, 8'd12, 16'd2100, 22'd0);
        send_word(OP_NONE, 8'hFF, 8'hFF, 16'hFFFF, 22'h3FFFFF);
        send_word(OP_SET, 8'd31, 8'd12, 16'd1999, 22'd0);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'd1);
        send_word(OP_ADD, 8'd0, 8'd0, 16'd0, 22'h3FFFFF);
        send_word(OP_DIFF, 8'd1, 8'd3, 16'd2000, 22'd0);
        // Sender pauses until all results are in
        wait_drained();
        send_random(600);
        // Receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        fork
            send_random(20);
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        send_random(630);
        wait_drained();
        if (fail_count == 0 && pending == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
